// ===== hw/rtl/imu_frame_deframer_crc16_core_assert.svh =====
// assertion macros for the deframer core
`ifndef IMU_FRAME_DEFRAMER_CRC16_CORE_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_CRC16_CORE_ASSERT_SVH

// same-cycle implication
`define IMUDF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imudf assertion failed");

// next-cycle implication
`define IMUDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imudf assertion failed");

`endif

// ===== hw/rtl/imudf_pkg.sv =====
// types, codes and crc function for the deframer
`default_nettype none
package imudf_pkg;

  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_START_FIRST  = 2'd0;
  localparam logic [1:0] REG_START_SECOND = 2'd1;
  localparam logic [1:0] REG_DATA_TAG     = 2'd2;
  localparam logic [1:0] REG_MIN_LENGTH   = 2'd3;

  localparam logic [1:0] PH_HUNT1   = 2'd0;
  localparam logic [1:0] PH_HUNT2   = 2'd1;
  localparam logic [1:0] PH_HEADER  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_GOOD_DATA  = 3'd1;
  localparam logic [2:0] ST_GOOD_OTHER = 3'd2;
  localparam logic [2:0] ST_CRC_ERR    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;
  localparam logic [2:0] ST_TRUNC      = 3'd5;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0] start_byte_first;
    logic [7:0] start_byte_second;
    logic [7:0] data_tag;
    logic [9:0] min_data_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  header_index;
    logic [15:0] frame_length;
    logic [15:0] received_check;
    logic [15:0] running_check;
    logic        tag_matched;
    logic [15:0] good_total;
  } frame_state_t;

  typedef struct packed {
    logic        has_result;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [2:0]  frame_status;
    logic [15:0] good_count;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/imudf_if.sv =====
// stream interfaces for received bytes and frame results
`default_nettype none
interface imudf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface imudf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        frame_end;
  logic [2:0]  frame_status;
  logic [15:0] good_count;

  modport source (output valid, output payload_byte, output byte_valid, output frame_end,
                  output frame_status, output good_count, input ready);
  modport sink (input valid, input payload_byte, input byte_valid, input frame_end,
                input frame_status, input good_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/imu_frame_deframer_crc16_core.sv =====
// top level of the start-pattern / length / crc-16 frame deframer
//
//   port     kind          direction  transaction
//   din      stream sink   in         one received byte and chunk_end flag
//   dout     stream source out        forwarded payload byte and/or frame verdict
//   apb      register bus  in/out     start bytes, data tag, minimum data length
//
// one byte per cycle sustained while dout is not stalled; din to dout passes through
// the input register, then one pass of crc and framing logic into the result register
// bytes that give no result update state and leave dout untouched
// a stalled dout holds its result; din keeps flowing while the input register can advance
// rst is synchronous and returns the parser to hunting with reset register values
`default_nettype none
module imu_frame_deframer_crc16_core
  import imudf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic               clk,
  input  wire logic               rst,
  imudf_in_if.sink                din,
  imudf_out_if.source             dout,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int unsigned PIW = $clog2(MAX_PAYLOAD + 1);

  cfg_t           cfg;
  frame_state_t   st;
  frame_state_t   st_next;
  logic [PIW-1:0] payload_index;
  logic [PIW-1:0] payload_index_next;
  result_t        res;

  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_last;
  logic           advance;
  logic [15:0]    pidx_ext;

  imudf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imudf_step #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .PIW         (PIW)
  ) u_step (
    .cfg       (cfg),
    .st        (st),
    .pidx      (payload_index),
    .rx_byte   (in_byte),
    .chunk_end (in_last),
    .st_next   (st_next),
    .pidx_next (payload_index_next),
    .res       (res)
  );

  assign advance   = in_valid && (!res.has_result || !dout.valid || dout.ready);
  assign din.ready = !in_valid || advance;
  assign pidx_ext  = 16'(payload_index);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.ready) begin
      in_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      in_byte <= din.rx_byte;
      in_last <= din.chunk_end;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_HUNT1;
      st.header_index   <= 2'd0;
      st.frame_length   <= 16'd0;
      st.received_check <= 16'd0;
      st.running_check  <= 16'd0;
      st.tag_matched    <= 1'b0;
      st.good_total     <= 16'd0;
      payload_index     <= '0;
    end else if (advance) begin
      st            <= st_next;
      payload_index <= payload_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance && res.has_result) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has_result) begin
      dout.payload_byte <= res.payload_byte;
      dout.byte_valid   <= res.byte_valid;
      dout.frame_end    <= res.frame_end;
      dout.frame_status <= res.frame_status;
      dout.good_count   <= res.good_count;
    end
  end

`include "imu_frame_deframer_crc16_core_assert.svh"

  `IMUDF_ASSERT_NOW(a_result_nonempty, clk, rst, dout.valid, dout.byte_valid || dout.frame_end)
  `IMUDF_ASSERT_NOW(a_status_only_at_end, clk, rst, dout.valid && !dout.frame_end, dout.frame_status == ST_NONE)
  `IMUDF_ASSERT_NOW(a_too_long_no_byte, clk, rst, dout.valid && dout.frame_status == ST_TOO_LONG, !dout.byte_valid)
  `IMUDF_ASSERT_NOW(a_payload_index_bound, clk, rst, st.phase == PH_PAYLOAD, pidx_ext < st.frame_length)

endmodule
`default_nettype wire

// ===== hw/rtl/imudf_cfg.sv =====
// apb configuration registers of the deframer
`default_nettype none
module imudf_cfg
  import imudf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte_first  <= 8'h5A;
      cfg.start_byte_second <= 8'hA5;
      cfg.data_tag          <= 8'h91;
      cfg.min_data_length   <= 10'd76;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_FIRST:  cfg.start_byte_first  <= pwdata[7:0];
        REG_START_SECOND: cfg.start_byte_second <= pwdata[7:0];
        REG_DATA_TAG:     cfg.data_tag          <= pwdata[7:0];
        REG_MIN_LENGTH:   cfg.min_data_length   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_FIRST:  prdata = {24'd0, cfg.start_byte_first};
      REG_START_SECOND: prdata = {24'd0, cfg.start_byte_second};
      REG_DATA_TAG:     prdata = {24'd0, cfg.data_tag};
      REG_MIN_LENGTH:   prdata = {22'd0, cfg.min_data_length};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/imudf_step.sv =====
// next-state and result logic for one received byte
`default_nettype none
module imudf_step
  import imudf_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512,
  parameter int unsigned PIW = $clog2(MAX_PAYLOAD + 1)
) (
  input  cfg_t               cfg,
  input  frame_state_t       st,
  input  wire logic [PIW-1:0] pidx,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          chunk_end,
  output frame_state_t       st_next,
  output logic [PIW-1:0]     pidx_next,
  output result_t            res
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  logic [PIW-1:0] pidx_inc;
  logic [15:0]    crc_upd;
  logic [15:0]    crc_first;
  logic           valid;
  logic           fend;
  logic [2:0]     status;

  assign pidx_inc  = pidx + 1'b1;
  assign crc_upd   = crc_byte(st.running_check, rx_byte);
  assign crc_first = crc_byte(16'd0, rx_byte);

  always_comb begin
    st_next   = st;
    pidx_next = pidx;
    valid     = 1'b0;
    fend      = 1'b0;
    status    = ST_NONE;

    case (st.phase)
      PH_HUNT1: begin
        if (rx_byte == cfg.start_byte_first) begin
          st_next.running_check = crc_first;
          st_next.phase         = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (rx_byte == cfg.start_byte_second) begin
          st_next.running_check = crc_upd;
          st_next.header_index  = 2'd0;
          st_next.phase         = PH_HEADER;
        end else if (rx_byte == cfg.start_byte_first) begin
          st_next.running_check = crc_first;
        end else begin
          st_next.phase = PH_HUNT1;
        end
      end
      PH_HEADER: begin
        case (st.header_index)
          2'd0: begin
            st_next.frame_length  = {8'd0, rx_byte};
            st_next.running_check = crc_upd;
            st_next.header_index  = 2'd1;
          end
          2'd1: begin
            st_next.frame_length  = {rx_byte, st.frame_length[7:0]};
            st_next.running_check = crc_upd;
            st_next.header_index  = 2'd2;
          end
          2'd2: begin
            st_next.received_check = {8'd0, rx_byte};
            st_next.header_index   = 2'd3;
          end
          default: begin
            st_next.received_check = {rx_byte, st.received_check[7:0]};
            st_next.header_index   = 2'd0;
            st_next.tag_matched    = 1'b0;
            pidx_next              = '0;
            if (st.frame_length > MAX_LEN) begin
              fend          = 1'b1;
              status        = ST_TOO_LONG;
              st_next.phase = PH_HUNT1;
            end else if (st.frame_length == 16'd0) begin
              fend          = 1'b1;
              st_next.phase = PH_HUNT1;
              if (st.running_check != st_next.received_check) begin
                status = ST_CRC_ERR;
              end else begin
                status = ST_GOOD_OTHER;
              end
            end else begin
              st_next.phase = PH_PAYLOAD;
            end
          end
        endcase
      end
      default: begin
        valid = 1'b1;
        if (pidx == '0) begin
          st_next.tag_matched = (rx_byte == cfg.data_tag);
        end
        st_next.running_check = crc_upd;
        pidx_next             = pidx_inc;
        if (16'(pidx_inc) >= st.frame_length) begin
          fend          = 1'b1;
          st_next.phase = PH_HUNT1;
          if (crc_upd != st.received_check) begin
            status = ST_CRC_ERR;
          end else if (st_next.tag_matched &&
                       st.frame_length >= {6'd0, cfg.min_data_length}) begin
            status             = ST_GOOD_DATA;
            st_next.good_total = st.good_total + 16'd1;
          end else begin
            status = ST_GOOD_OTHER;
          end
        end
      end
    endcase

    if (chunk_end) begin
      if (st_next.phase == PH_HEADER || st_next.phase == PH_PAYLOAD) begin
        fend   = 1'b1;
        status = ST_TRUNC;
      end
      st_next.phase        = PH_HUNT1;
      st_next.header_index = 2'd0;
    end
  end

  always_comb begin
    res.has_result   = valid || fend;
    res.payload_byte = valid ? rx_byte : 8'd0;
    res.byte_valid   = valid;
    res.frame_end    = fend;
    res.frame_status = fend ? status : ST_NONE;
    res.good_count   = st_next.good_total;
  end

endmodule
`default_nettype wire

// ===== test/imudf_frame_checker.sv =====
// crc helper, result type and scoreboard that predicts and checks deframer results
`timescale 1ns / 1ps
package imudf_tb_pkg;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [2:0]  frame_status;
    logic [15:0] good_count;
  } frame_result_t;

  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ imudf_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

module imudf_frame_checker
  import imudf_pkg::*, imudf_tb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic               clk,
  input  logic               rst,
  imudf_in_if                din,
  imudf_out_if               dout,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending
);

  logic [7:0]  sof_first;
  logic [7:0]  sof_second;
  logic [7:0]  tag_byte;
  logic [9:0]  min_len;

  logic [1:0]  parse_phase;
  logic [1:0]  hdr_idx;
  logic [15:0] frame_len;
  logic [15:0] rx_crc;
  logic [15:0] run_crc;
  logic [9:0]  pay_idx;
  logic        tag_hit;
  logic [15:0] good_total;

  frame_result_t results_due[$];
  int            fails;

  function automatic void clear_parser();
    sof_first   = 8'h5A;
    sof_second  = 8'hA5;
    tag_byte    = 8'h91;
    min_len     = 10'd76;
    parse_phase = PH_HUNT1;
    hdr_idx     = 2'd0;
    frame_len   = 16'd0;
    rx_crc      = 16'd0;
    run_crc     = 16'd0;
    pay_idx     = 10'd0;
    tag_hit     = 1'b0;
    good_total  = 16'd0;
  endfunction

  function automatic logic [2:0] frame_verdict();
    logic [2:0] st;
    if (run_crc != rx_crc) begin
      st = ST_CRC_ERR;
    end else if (tag_hit && frame_len >= {6'd0, min_len}) begin
      st = ST_GOOD_DATA;
      good_total = good_total + 16'd1;
    end else begin
      st = ST_GOOD_OTHER;
    end
    parse_phase = PH_HUNT1;
    return st;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                      output frame_result_t res);
    bit         bv;
    bit         fe;
    logic [2:0] st;
    bv = 1'b0;
    fe = 1'b0;
    st = ST_NONE;
    case (parse_phase)
      PH_HUNT1: begin
        if (b == sof_first) begin
          run_crc     = crc16_ccitt_step(16'h0000, b);
          parse_phase = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (b == sof_second) begin
          run_crc     = crc16_ccitt_step(run_crc, b);
          hdr_idx     = 2'd0;
          parse_phase = PH_HEADER;
        end else if (b == sof_first) begin
          run_crc = crc16_ccitt_step(16'h0000, b);
        end else begin
          parse_phase = PH_HUNT1;
        end
      end
      PH_HEADER: begin
        case (hdr_idx)
          2'd0: begin
            frame_len = {8'h00, b};
            run_crc   = crc16_ccitt_step(run_crc, b);
            hdr_idx   = 2'd1;
          end
          2'd1: begin
            frame_len[15:8] = b;
            run_crc         = crc16_ccitt_step(run_crc, b);
            hdr_idx         = 2'd2;
          end
          2'd2: begin
            rx_crc  = {8'h00, b};
            hdr_idx = 2'd3;
          end
          default: begin
            rx_crc[15:8] = b;
            hdr_idx      = 2'd0;
            pay_idx      = 10'd0;
            tag_hit      = 1'b0;
            if (frame_len > MAX_PAYLOAD) begin
              fe          = 1'b1;
              st          = ST_TOO_LONG;
              parse_phase = PH_HUNT1;
            end else if (frame_len == 16'd0) begin
              fe = 1'b1;
              st = frame_verdict();
            end else begin
              parse_phase = PH_PAYLOAD;
            end
          end
        endcase
      end
      default: begin
        bv = 1'b1;
        if (pay_idx == 10'd0) begin
          tag_hit = (b == tag_byte);
        end
        run_crc = crc16_ccitt_step(run_crc, b);
        pay_idx = pay_idx + 10'd1;
        if ({6'd0, pay_idx} >= frame_len) begin
          fe = 1'b1;
          st = frame_verdict();
        end
      end
    endcase
    if (last) begin
      if (parse_phase == PH_HEADER || parse_phase == PH_PAYLOAD) begin
        fe = 1'b1;
        st = ST_TRUNC;
      end
      parse_phase = PH_HUNT1;
      hdr_idx     = 2'd0;
    end
    res.payload_byte = bv ? b : 8'h00;
    res.byte_valid   = bv;
    res.frame_end    = fe;
    res.frame_status = fe ? st : ST_NONE;
    res.good_count   = good_total;
    return bv || fe;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (rst) begin
      clear_parser();
      results_due.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_START_FIRST:  sof_first  = pwdata[7:0];
          REG_START_SECOND: sof_second = pwdata[7:0];
          REG_DATA_TAG:     tag_byte   = pwdata[7:0];
          REG_MIN_LENGTH:   min_len    = pwdata[9:0];
          default: ;
        endcase
      end
      if (dout.valid && dout.ready) begin
        got.payload_byte = dout.payload_byte;
        got.byte_valid   = dout.byte_valid;
        got.frame_end    = dout.frame_end;
        got.frame_status = dout.frame_status;
        got.good_count   = dout.good_count;
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: byte %h valid %b end %b status %0d count %0d",
                     got.payload_byte, got.byte_valid, got.frame_end, got.frame_status,
                     got.good_count);
          end
        end else begin
          want = results_due.pop_front();
          if (got.payload_byte !== want.payload_byte || got.byte_valid !== want.byte_valid ||
              got.frame_end !== want.frame_end || got.frame_status !== want.frame_status ||
              got.good_count !== want.good_count) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected byte %h valid %b end %b status %0d count %0d",
                       want.payload_byte, want.byte_valid, want.frame_end, want.frame_status,
                       want.good_count);
              $display("          actual   byte %h valid %b end %b status %0d count %0d",
                       got.payload_byte, got.byte_valid, got.frame_end, got.frame_status,
                       got.good_count);
            end
          end
        end
      end
      if (din.valid && din.ready) begin
        if (deframe_byte(din.rx_byte, din.chunk_end, want)) begin
          results_due.push_back(want);
        end
      end
    end
    errors  <= fails;
    pending <= results_due.size();
  end

endmodule

// ===== test/tb.sv =====
// top of the deframer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import imudf_pkg::*;
  import imudf_tb_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  logic [7:0] cfg_sof0;
  logic [7:0] cfg_sof1;
  logic [7:0] cfg_tag;
  logic [9:0] cfg_min;
  logic [7:0] frame_bytes[$];
  bit         gaps_on;
  bit         stalls_on;
  bit         keep_busy;
  bit         hold_request;
  int         items_sent;

  imudf_in_if  din_if ();
  imudf_out_if dout_if ();

  imu_frame_deframer_crc16_core #(.MAX_PAYLOAD(512)) uut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  imudf_frame_checker #(.MAX_PAYLOAD(512)) chk (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always #2 clk = ~clk;

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (gaps_on && !keep_busy) ? $urandom_range(18, 0) : 0;
    if (gap != 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.rx_byte   <= b;
    din_if.chunk_end <= last;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(input int count, input int last_at);
    for (int i = 0; i < count; i++) begin
      send_byte(frame_bytes[i], i == last_at);
    end
  endtask

  task automatic build_frame(input logic [15:0] len, input bit tag_first, input bit bad_crc);
    logic [15:0] crc;
    logic [7:0]  b;
    logic [7:0]  body[$];
    frame_bytes.delete();
    crc = 16'h0000;
    crc = crc16_ccitt_step(crc, cfg_sof0);
    crc = crc16_ccitt_step(crc, cfg_sof1);
    crc = crc16_ccitt_step(crc, len[7:0]);
    crc = crc16_ccitt_step(crc, len[15:8]);
    if (len <= 16'd512) begin
      for (int i = 0; i < len; i++) begin
        b = (i == 0 && tag_first) ? cfg_tag : 8'($urandom_range(255, 0));
        crc = crc16_ccitt_step(crc, b);
        body.push_back(b);
      end
    end
    if (bad_crc) begin
      crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
    end
    frame_bytes = {cfg_sof0, cfg_sof1, len[7:0], len[15:8], crc[7:0], crc[15:8], body};
  endtask

  task automatic random_frame();
    int unsigned pick;
    logic [15:0] len;
    int          last_at;
    int          n;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      len = 16'($urandom_range(12, 1));
    end else if (pick < 65) begin
      len = 16'd0;
    end else if (pick < 77 && cfg_min <= 10'd40) begin
      len = (cfg_min == 10'd0) ? 16'($urandom_range(1, 0))
                               : 16'({22'd0, cfg_min} - 1 + $urandom_range(2, 0));
    end else if (pick < 87) begin
      len = ($urandom_range(1, 0) == 1) ? 16'd513 : 16'($urandom_range(65535, 513));
    end else begin
      len = 16'($urandom_range(40, 13));
    end
    build_frame(len, $urandom_range(1, 0) == 1, $urandom_range(4, 0) == 0);
    if ($urandom_range(9, 0) == 0) begin
      frame_bytes.push_front(cfg_sof0);
    end
    n    = frame_bytes.size();
    pick = $urandom_range(19, 0);
    if (pick < 3) begin
      last_at = $urandom_range(n - 1, 0);
      n       = last_at + 1;
    end else if (pick < 5) begin
      last_at = n - 1;
    end else begin
      last_at = -1;
    end
    send_bytes(n, last_at);
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      send_byte(($urandom_range(3, 0) == 0) ? cfg_sof0 : 8'($urandom_range(255, 0)),
                $urandom_range(9, 0) == 0);
    end
  endtask

  task automatic run_random(input int budget);
    int target;
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(5, 0) == 0) begin
        gaps_on = !gaps_on;
      end
      if ($urandom_range(4, 0) == 0) begin
        noise_burst();
      end else begin
        random_frame();
      end
    end
  endtask

  task automatic settle();
    din_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] s0, input logic [7:0] s1,
                              input logic [7:0] tg, input logic [9:0] ml);
    settle();
    write_reg(REG_START_FIRST, {24'd0, s0});
    write_reg(REG_START_SECOND, {24'd0, s1});
    write_reg(REG_DATA_TAG, {24'd0, tg});
    write_reg(REG_MIN_LENGTH, {22'd0, ml});
    cfg_sof0 = s0;
    cfg_sof1 = s1;
    cfg_tag  = tg;
    cfg_min  = ml;
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int unsigned wait_n;
    stalls_on = 1'b1;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        dout_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if ($urandom_range(15, 0) == 0) begin
        stalls_on = !stalls_on;
      end
      wait_n = stalls_on ? $urandom_range(18, 0) : 0;
      if (wait_n != 0) begin
        dout_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      @(posedge clk);
      while (!(dout_if.valid && dout_if.ready)) @(posedge clk);
    end
  end

  initial begin
    rst              <= 1'b1;
    din_if.valid     <= 1'b0;
    din_if.rx_byte   <= 8'h00;
    din_if.chunk_end <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= 32'd0;
    cfg_sof0         = 8'h5A;
    cfg_sof1         = 8'hA5;
    cfg_tag          = 8'h91;
    cfg_min          = 10'd76;
    gaps_on          = 1'b1;
    keep_busy        = 1'b0;
    hold_request     = 1'b0;
    items_sent       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // noise, half start pattern dropped at chunk end
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    // rescan of the first start byte, zero length good and bad
    build_frame(16'd0, 1'b0, 1'b0);
    frame_bytes.push_front(cfg_sof0);
    send_bytes(frame_bytes.size(), -1);
    build_frame(16'd0, 1'b0, 1'b1);
    send_bytes(frame_bytes.size(), -1);
    // just over the maximum length
    build_frame(16'd513, 1'b0, 1'b0);
    send_bytes(frame_bytes.size(), -1);
    // truncated in the payload and in the header
    build_frame(16'd3, 1'b1, 1'b0);
    send_bytes(7, 6);
    build_frame(16'd5, 1'b0, 1'b0);
    send_bytes(3, 2);
    run_random(80);

    apply_config(8'h00, 8'hFF, 8'h00, 10'd1);
    run_random(90);

    apply_config(8'hFF, 8'h00, 8'hFF, 10'd512);
    build_frame(16'd512, 1'b1, 1'b0);
    send_bytes(frame_bytes.size(), -1);
    run_random(60);

    apply_config(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), 10'd0);
    keep_busy    = 1'b1;
    hold_request = 1'b1;
    run_random(60);
    keep_busy = 1'b0;
    run_random(50);

    apply_config(8'h5A, 8'hA5, 8'h91, 10'd1023);
    run_random(40);
    settle();
    run_random(40);

    apply_config(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), 10'($urandom_range(40, 1)));
    run_random(90);

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
